### src/multichannel_attack_decay_envelope_assert.svh
// Assertion macros shared by the envelope bank RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTICHANNEL_ATTACK_DECAY_ENVELOPE_ASSERT_SVH
`define MULTICHANNEL_ATTACK_DECAY_ENVELOPE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MCAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define MCAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mcad_pkg.sv
// Package of the envelope bank: field widths, opcodes, phase codes,
// per-channel entry layout and reset values. Depends on nothing.
`timescale 1ns / 1ps

package mcad_pkg;

   // Field widths
   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 8;
   localparam int COEF_W    = 32;
   localparam int TIMER_W   = 32;
   localparam int LEVEL_W   = 16;
   localparam int ENV_W     = 31;
   localparam int PHASE_W   = 2;

   // Parameter defaults
   localparam int CHANNELS_DEFAULT   = 256;
   localparam int TICK_SHIFT_DEFAULT = 13;

   // Envelope constants
   localparam logic [31:0] FULL_SCALE  = 32'h7FFF_FFFF;
   localparam logic [31:0] LONG_GAP    = 32'h0004_0000;
   localparam int          LEVEL_SHIFT = 15;
   localparam logic [31:0] DEF_ATTACK  = 32'h0511_B300;
   localparam logic [31:0] DEF_DECAY   = 32'hFAEE_4D00;

   // Step count is at most LONG_GAP, so it fits in its bit length
   localparam int STEP_W = $clog2(LONG_GAP + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_UPDATE      = 2'd0,
      OP_SET_GATE    = 2'd1,
      OP_LOAD_ATTACK = 2'd2,
      OP_LOAD_DECAY  = 2'd3
   } opcode_type;

   localparam logic [PHASE_W-1:0] PH_DECAY  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACK = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HOLD   = 2'd2;

   typedef struct packed {
      logic [COEF_W-1:0]  decay_coef;
      logic [COEF_W-1:0]  attack_coef;
      logic [TIMER_W-1:0] last_time;
      logic               gate_held;
      logic [PHASE_W-1:0] phase;
      logic [ENV_W-1:0]   env_value;
   } chan_entry_type;

   localparam chan_entry_type ENTRY_RESET = '{
      decay_coef:  DEF_DECAY,
      attack_coef: DEF_ATTACK,
      last_time:   '0,
      gate_held:   1'b0,
      phase:       PH_DECAY,
      env_value:   '0
   };

endpackage

### src/mcad_if.sv
// Request and response channel interfaces of the envelope bank.
// Depends on mcad_pkg for the field widths.
`timescale 1ns / 1ps

interface mcad_req_if
   import mcad_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [CHANNEL_W-1:0] channel;
   logic                 gate_level;
   logic [COEF_W-1:0]    coefficient;
   logic [TIMER_W-1:0]   timer_now;

   modport source (output valid, opcode, channel, gate_level, coefficient, timer_now,
                   input ready);
   modport sink   (input valid, opcode, channel, gate_level, coefficient, timer_now,
                   output ready);
endinterface

interface mcad_rsp_if
   import mcad_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, level, input ready);
   modport sink   (input valid, level, output ready);
endinterface

### src/multichannel_attack_decay_envelope.sv
// Channel  Dir  Payload                                            Transaction
// req_chan in   opcode, channel, gate_level, coefficient, timer_now valid & ready
// rsp_chan out  level                                              valid & ready
//
// Gate and coefficient transactions pass through accept, read and write back.
// Update runs one 32x32 multiply and one add/compare per step (none in hold);
// steps <= 0x40000 >> TICK_SHIFT (32 at 13), fewer on clamp or zero.
// After reset a clearing pass writes every entry, with req ready low.
// A waiting response does not block acceptance; a finished update holds until
// the response register is free.
//
// Envelope bank top level: per-channel state in one synchronous memory,
// read-modify-write sequencer. Depends on mcad_pkg, mcad_if and the assert header.
`timescale 1ns / 1ps
`include "multichannel_attack_decay_envelope_assert.svh"

module multichannel_attack_decay_envelope
   import mcad_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int TICK_SHIFT = TICK_SHIFT_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mcad_req_if.sink  req_chan,
   mcad_rsp_if.source rsp_chan
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IW = (AW > CHANNEL_W) ? AW : CHANNEL_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_ADD, ST_WRITE, ST_DONE
   } state_type;

   // Control and response registers
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_idx_ff, clr_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   // Transaction and working registers
   opcode_type         op_ff, op_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               ch_ok_ff, ch_ok_in;
   logic               gate_ff, gate_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;
   logic [TIMER_W-1:0] now_ff, now_in;
   logic [ENV_W-1:0]   env_ff, env_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               held_ff, held_in;
   logic [TIMER_W-1:0] last_ff, last_in;
   logic [COEF_W-1:0]  acoef_ff, acoef_in;
   logic [COEF_W-1:0]  dcoef_ff, dcoef_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [63:0]        prod_ff, prod_in;

   // Memory ports
   chan_entry_type     mem [CHANNELS];
   chan_entry_type     rd_ff;
   chan_entry_type     mem_wdata;
   chan_entry_type     work_entry;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;

   // Datapath helpers
   logic               req_accept;
   logic [IW-1:0]      req_ch_wide;
   logic               req_ch_ok;
   logic [TIMER_W-1:0] elapsed;
   logic [STEP_W-1:0]  step_count;
   logic [31:0]        mul_a, mul_b;
   logic [31:0]        hi_word;
   logic [31:0]        attack_sum;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = rsp_level_ff;

   // Map the channel field onto a memory address and range check it
   assign req_ch_wide = IW'(req_chan.channel);
   assign mem_raddr   = req_ch_wide[AW-1:0];
   assign req_ch_ok   = 32'(req_chan.channel) < 32'(CHANNELS);

   // Quantize elapsed time into a step count; a long gap counts as one step
   assign elapsed    = now_ff - rd_ff.last_time;
   assign step_count = (elapsed > LONG_GAP) ? STEP_W'(1) : STEP_W'(elapsed >> TICK_SHIFT);

   // One step: attack works on the 32-bit complement of the level, decay on the level
   assign mul_a      = (phase_ff == PH_ATTACK) ? ~{1'b0, env_ff} : {1'b0, env_ff};
   assign mul_b      = (phase_ff == PH_ATTACK) ? acoef_ff : dcoef_ff;
   assign hi_word    = prod_ff[63:32];
   assign attack_sum = {1'b0, env_ff} + hi_word;

   assign work_entry = '{
      decay_coef:  dcoef_ff,
      attack_coef: acoef_ff,
      last_time:   last_ff,
      gate_held:   held_ff,
      phase:       phase_ff,
      env_value:   env_ff
   };

   // Clear every entry after reset, then sequence each transaction: read, modify, write back, respond
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_level_in = rsp_level_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      ch_ok_in     = ch_ok_ff;
      gate_in      = gate_ff;
      coef_in      = coef_ff;
      now_in       = now_ff;
      env_in       = env_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      last_in      = last_ff;
      acoef_in     = acoef_ff;
      dcoef_in     = dcoef_ff;
      steps_in     = steps_ff;
      prod_in      = prod_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = work_entry;

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = ENTRY_RESET;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = opcode_type'(req_chan.opcode);
               addr_in  = mem_raddr;
               ch_ok_in = req_ch_ok;
               gate_in  = req_chan.gate_level;
               coef_in  = req_chan.coefficient;
               now_in   = req_chan.timer_now;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            env_in   = rd_ff.env_value;
            phase_in = rd_ff.phase;
            held_in  = rd_ff.gate_held;
            last_in  = rd_ff.last_time;
            acoef_in = rd_ff.attack_coef;
            dcoef_in = rd_ff.decay_coef;
            if (!ch_ok_ff) begin
               // Out-of-range channel: updates report zero, the rest drop
               env_in   = '0;
               state_in = (op_ff == OP_UPDATE) ? ST_DONE : ST_IDLE;
            end else begin
               case (op_ff)
                  OP_UPDATE: begin
                     steps_in = step_count;
                     if (step_count == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        last_in  = now_ff;
                        state_in = (rd_ff.phase == PH_HOLD) ? ST_WRITE : ST_MUL;
                     end
                  end
                  OP_SET_GATE: begin
                     held_in = gate_ff;
                     if (gate_ff && !rd_ff.gate_held) begin
                        phase_in = PH_ATTACK;
                     end else if (!gate_ff) begin
                        phase_in = PH_DECAY;
                     end
                     state_in = ST_WRITE;
                  end
                  OP_LOAD_ATTACK: begin
                     acoef_in = coef_ff;
                     state_in = ST_WRITE;
                  end
                  OP_LOAD_DECAY: begin
                     dcoef_in = coef_ff;
                     state_in = ST_WRITE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            steps_in = steps_ff - STEP_W'(1);
            if (phase_ff == PH_ATTACK) begin
               if (attack_sum > FULL_SCALE) begin
                  // Reached full scale: clamp, hold, drop the remaining steps
                  env_in   = FULL_SCALE[ENV_W-1:0];
                  phase_in = PH_HOLD;
                  state_in = ST_WRITE;
               end else begin
                  env_in   = attack_sum[ENV_W-1:0];
                  state_in = (steps_ff == STEP_W'(1)) ? ST_WRITE : ST_MUL;
               end
            end else begin
               // Decay stays at zero once there, so stop early
               env_in   = hi_word[ENV_W-1:0];
               state_in = (steps_ff == STEP_W'(1) || hi_word == '0) ? ST_WRITE : ST_MUL;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = (op_ff == OP_UPDATE) ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = env_ff[LEVEL_SHIFT +: LEVEL_W];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_level_ff <= rsp_level_in;
   end

   // Advance working registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      ch_ok_ff <= ch_ok_in;
      gate_ff  <= gate_in;
      coef_ff  <= coef_in;
      now_ff   <= now_in;
      env_ff   <= env_in;
      phase_ff <= phase_in;
      held_ff  <= held_in;
      last_ff  <= last_in;
      acoef_ff <= acoef_in;
      dcoef_ff <= dcoef_in;
      steps_ff <= steps_in;
      prod_ff  <= prod_in;
   end

   // Channel state memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   `MCAD_ASSERT_NOW(a_no_accept_on_write, clock, reset, mem_we, !req_accept,
                    "write during accept")
   `MCAD_ASSERT_NOW(a_steps_left, clock, reset, state_ff == ST_MUL, steps_ff != '0,
                    "no step left")
   `MCAD_ASSERT_NEXT(a_add_exit, clock, reset, state_ff == ST_ADD,
                     state_ff == ST_MUL || state_ff == ST_WRITE, "bad step exit")
   `MCAD_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == ST_DONE, "stray response")

endmodule
